// ===== rtl/hsec_pkg.sv =====
// ----------------------------------------------------------------------------
// hsec_pkg
// Shared types, constants and code-layout functions for the Hamming
// single-error-correcting encoder and corrector.
// ----------------------------------------------------------------------------
package hsec_pkg;

  localparam int WordW = 63;
  localparam int PosW = 6;
  localparam int MaxDataBitsDef = 57;

  typedef enum logic {
    KIND_ENCODE  = 1'b0,
    KIND_CORRECT = 1'b1
  } kind_t;

  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] word_in;
  } hsec_in_t;

  typedef struct packed {
    logic [WordW-1:0] word_out;
    logic [PosW-1:0]  error_position;
    logic             syndrome_out_of_range;
  } hsec_out_t;

  // Word after masking or scattering, with the codeword length n.
  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] word;
    logic [PosW-1:0]  n;
  } hsec_s1_t;

  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] word;
    logic [PosW-1:0]  n;
    logic [PosW-1:0]  syn;
  } hsec_s2_t;

  // Codeword length n = m + r, where r is the least value with 2^r >= m + r + 1.
  function automatic logic [PosW-1:0] code_len(input logic [PosW-1:0] m);
    logic [PosW-1:0] r;
    r = '0;
    for (int k = 0; k < 7; k++) begin
      if ((7'd1 << r) < (7'(m) + 7'(r) + 7'd1)) begin
        r = r + 6'd1;
      end
    end
    return m + r;
  endfunction

  // Data bit j goes to the (j+1)-th code position that is not a power of two.
  function automatic logic [WordW-1:0] scatter(input logic [WordW-1:0] data);
    logic [WordW-1:0] res;
    int j;
    res = '0;
    j = 0;
    for (int p = 1; p <= WordW; p++) begin
      if ((p & (p - 1)) != 0) begin
        res[p-1] = data[j];
        j++;
      end
    end
    return res;
  endfunction

  // Positions whose index has bit i set; the syndrome bit i is the parity over them.
  function automatic logic [WordW-1:0] syn_col(input int i);
    logic [WordW-1:0] col;
    col = '0;
    for (int p = 1; p <= WordW; p++) begin
      col[p-1] = ((p >> i) & 1) != 0;
    end
    return col;
  endfunction

endpackage

// ===== rtl/hsec_prep.sv =====
// ----------------------------------------------------------------------------
// hsec_prep
// First pipeline stage: derives n from the configured data count, masks the
// codeword or scatters the data bits into their code positions.
// ----------------------------------------------------------------------------
module hsec_prep #(
  parameter int MAX_DATA_BITS = hsec_pkg::MaxDataBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [hsec_pkg::PosW-1:0]     data_bits,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hsec_pkg::hsec_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hsec_pkg::hsec_s1_t            out_data
);

  logic [hsec_pkg::PosW-1:0]  m_eff;
  logic [hsec_pkg::PosW-1:0]  n;
  logic [hsec_pkg::WordW-1:0] mask_m;
  logic [hsec_pkg::WordW-1:0] mask_n;
  hsec_pkg::hsec_s1_t         stage_next;

  always_comb begin
    if (data_bits == '0) begin
      m_eff = 6'd1;
    end else if (data_bits > hsec_pkg::PosW'(MAX_DATA_BITS)) begin
      m_eff = hsec_pkg::PosW'(MAX_DATA_BITS);
    end else begin
      m_eff = data_bits;
    end
    n = hsec_pkg::code_len(m_eff);
    for (int i = 0; i < hsec_pkg::WordW; i++) begin
      mask_m[i] = 7'(i) < 7'(m_eff);
      mask_n[i] = 7'(i) < 7'(n);
    end
    stage_next.kind = in_data.kind;
    stage_next.n = n;
    if (in_data.kind == hsec_pkg::KIND_CORRECT) begin
      stage_next.word = in_data.word_in & mask_n;
    end else begin
      stage_next.word = hsec_pkg::scatter(in_data.word_in & mask_m);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

// ===== rtl/hsec_syn.sv =====
// ----------------------------------------------------------------------------
// hsec_syn
// Second pipeline stage: syndrome of the prepared word, one parity tree for
// each syndrome bit.
// ----------------------------------------------------------------------------
module hsec_syn (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsec_pkg::hsec_s1_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hsec_pkg::hsec_s2_t out_data
);

  hsec_pkg::hsec_s2_t stage_next;

  always_comb begin
    stage_next.kind = in_data.kind;
    stage_next.word = in_data.word;
    stage_next.n = in_data.n;
    for (int i = 0; i < hsec_pkg::PosW; i++) begin
      stage_next.syn[i] = ^(in_data.word & hsec_pkg::syn_col(i));
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

// ===== rtl/hsec_fix.sv =====
// ----------------------------------------------------------------------------
// hsec_fix
// Final pipeline stage: inserts parity bits on encode, or flips the bit the
// syndrome points at on correct, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module hsec_fix (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsec_pkg::hsec_s2_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hsec_pkg::hsec_out_t out_data
);

  hsec_pkg::hsec_out_t        res_next;
  logic [hsec_pkg::WordW-1:0] flip;
  logic                       beyond;

  always_comb begin
    beyond = in_data.syn > in_data.n;
    flip = '0;
    if (in_data.syn != '0 && !beyond) begin
      flip = hsec_pkg::WordW'(1) << (in_data.syn - 6'd1);
    end
    res_next.word_out = in_data.word;
    res_next.error_position = '0;
    res_next.syndrome_out_of_range = 1'b0;
    if (in_data.kind == hsec_pkg::KIND_CORRECT) begin
      res_next.word_out = in_data.word ^ flip;
      res_next.error_position = in_data.syn;
      res_next.syndrome_out_of_range = beyond;
    end else begin
      // Power-of-two positions are still zero here, so the syndrome is the parity.
      for (int i = 0; i < hsec_pkg::PosW; i++) begin
        res_next.word_out[(1 << i) - 1] = in_data.syn[i];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res_next;
    end
  end

endmodule

// ===== rtl/hamming_sec_encode_correct.sv =====
// ----------------------------------------------------------------------------
// hamming_sec_encode_correct
// Hamming single-error-correcting encoder and corrector with a configurable
// number of data bits.
// ----------------------------------------------------------------------------
// Each transaction on the input either encodes up to MAX_DATA_BITS data bits into a
// codeword or checks and repairs a codeword; code position p is word bit p-1.
// The work runs through a three-stage pipeline (prepare, syndrome, repair),
// each of which registers its result, so one transaction is taken every
// cycle unless the output stalls; a stalled output holds the pipeline in
// place without loss. The data bit count is written through cfg_we/cfg_wdata
// and resets to 4; change it only while no transaction is in flight.
module hamming_sec_encode_correct #(
  parameter int MAX_DATA_BITS = hsec_pkg::MaxDataBitsDef
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [hsec_pkg::PosW-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hsec_pkg::hsec_in_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hsec_pkg::hsec_out_t       out_data
);

  logic [hsec_pkg::PosW-1:0] data_bits;
  logic                      s1_valid;
  logic                      s1_ready;
  hsec_pkg::hsec_s1_t        s1_data;
  logic                      s2_valid;
  logic                      s2_ready;
  hsec_pkg::hsec_s2_t        s2_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits <= 6'd4;
    end else if (cfg_we) begin
      data_bits <= cfg_wdata;
    end
  end

  hsec_prep #(
    .MAX_DATA_BITS(MAX_DATA_BITS)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .data_bits (data_bits),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  hsec_syn u_syn (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  hsec_fix u_fix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
